### design/c3f_pkg.sv
// ----------------------------------------------------------------------------
// c3f_pkg: shared types and constants of the 3x3 image filter
// Window and queue entry types, filter mode codes and clamp limits.
// ----------------------------------------------------------------------------
package c3f_pkg;

    // Filter mode codes; any other code acts as box smoothing.
    localparam logic [1:0] MODE_SOBEL   = 2'd0;
    localparam logic [1:0] MODE_LAPLACE = 2'd1;
    localparam logic [1:0] MODE_BOX     = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Clamp limits and the reciprocal of nine in 16-bit fixed point.
    localparam int SOBEL_MAX   = 4 * 255;
    localparam int LAPLACE_MAX = 255;
    localparam int SMOOTH_MAX  = 9 * 255;
    localparam int RECIP9      = 7282;

    // Depth of the queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam int QAW    = $clog2(QDEPTH);

    // One column of the window: three packed RGB pixels, upper row first.
    typedef logic [2:0][23:0] column_t;

    // One queued window with the results it calls for.
    typedef struct packed {
        column_t [2:0] win;
        logic          emit_a;   // result centred on the middle column
        logic          emit_b;   // row-end result with the right edge replicated
        logic          eof;      // row-end result closes the frame
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

endpackage

### design/c3f_front.sv
// ----------------------------------------------------------------------------
// c3f_front: pixel intake, line stores and window
// Classifies each word against the frame position, keeps the two line
// stores and the three-column window, and queues windows that give results.
// ----------------------------------------------------------------------------
module c3f_front import c3f_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [11:0]     frame_width,
    input  logic [11:0]     frame_height,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [23:0]     s_tdata,
    input  logic            s_tuser,
    input  logic [QCW-1:0]  q_count,
    output push_t           push
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    logic [WW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          accept, take, drain_row, row_end;

    logic          s1_valid_reg, s1_drain_reg, s1_row0_reg, s1_first_reg;
    logic          s1_emit_a_reg, s1_emit_b_reg;
    logic [23:0]   s1_px_reg;
    logic [AW-1:0] s1_addr_reg;

    logic [23:0]   upper_mem  [MAX_WIDTH];
    logic [23:0]   middle_mem [MAX_WIDTH];
    logic [23:0]   upper_rd_reg, middle_rd_reg;
    logic          wr_en;
    logic [23:0]   wr_upper;

    column_t          col_now;
    column_t [2:0]    win_reg, win_next;

    // Effective geometry: zero acts as one, large values saturate.
    always_comb begin
        if (frame_width == 12'd0) begin
            eff_w = WW'(1);
        end else if (32'(frame_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(frame_width);
        end
        if (frame_height == 12'd0) begin
            eff_h = RW'(1);
        end else if (32'(frame_height) > MAX_HEIGHT) begin
            eff_h = RW'(MAX_HEIGHT);
        end else begin
            eff_h = RW'(frame_height);
        end
    end

    // Credit check: queued entries plus the one in flight must leave a slot.
    assign s_tready  = (32'(q_count) + 32'(s1_valid_reg)) < QDEPTH;
    assign accept    = s_tvalid && s_tready;
    assign drain_row = 32'(row_reg) >= 32'(eff_h);
    assign take      = accept && (s_tuser == drain_row);
    assign row_end   = (32'(col_reg) + 1) >= 32'(eff_w);

    // Frame position follows every word that is taken.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (take) begin
            if (row_end) begin
                col_next = '0;
                row_next = s_tuser ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= take;
            win_reg      <= win_next;
        end
    end

    // Per-word details carried alongside the line store read.
    always_ff @(posedge aclk) begin
        if (take) begin
            s1_px_reg     <= s_tdata;
            s1_drain_reg  <= s_tuser;
            s1_row0_reg   <= (row_reg == '0);
            s1_first_reg  <= (col_reg == '0);
            s1_emit_a_reg <= (row_reg != '0) && (col_reg != '0);
            s1_emit_b_reg <= (row_reg != '0) && row_end;
            s1_addr_reg   <= col_reg;
        end
    end

    // Line stores: written one stage after the read, with write-to-read bypass.
    assign wr_en    = s1_valid_reg && !s1_drain_reg;
    assign wr_upper = s1_row0_reg ? s1_px_reg : middle_rd_reg;

    always_ff @(posedge aclk) begin
        if (take) begin
            if (wr_en && s1_addr_reg == col_reg) begin
                upper_rd_reg  <= wr_upper;
                middle_rd_reg <= s1_px_reg;
            end else begin
                upper_rd_reg  <= upper_mem[col_reg];
                middle_rd_reg <= middle_mem[col_reg];
            end
        end
        if (wr_en) begin
            upper_mem[s1_addr_reg]  <= wr_upper;
            middle_mem[s1_addr_reg] <= s1_px_reg;
        end
    end

    // New window column, then shift or refill the window.
    always_comb begin
        if (s1_drain_reg) begin
            col_now = {middle_rd_reg, middle_rd_reg, upper_rd_reg};
        end else if (s1_row0_reg) begin
            col_now = {s1_px_reg, s1_px_reg, s1_px_reg};
        end else begin
            col_now = {s1_px_reg, middle_rd_reg, upper_rd_reg};
        end
        win_next = win_reg;
        if (s1_valid_reg) begin
            if (s1_first_reg) begin
                win_next = {col_now, col_now, col_now};
            end else begin
                win_next = {col_now, win_reg[2], win_reg[1]};
            end
        end
    end

    // Queue only windows that give at least one result.
    always_comb begin
        push.valid        = s1_valid_reg && (s1_emit_a_reg || s1_emit_b_reg);
        push.entry.win    = win_next;
        push.entry.emit_a = s1_emit_a_reg;
        push.entry.emit_b = s1_emit_b_reg;
        push.entry.eof    = s1_drain_reg;
    end

endmodule

### design/c3f_queue.sv
// ----------------------------------------------------------------------------
// c3f_queue: window queue between the front and back parts
// A short register FIFO that absorbs the second result at each row end.
// ----------------------------------------------------------------------------
module c3f_queue import c3f_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  push_t          push,
    input  logic           pop,
    output entry_t         head,
    output logic [QCW-1:0] count
);

    entry_t         slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_reg + QCW'(push.valid) - QCW'(pop);
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> (32'(count_reg) < QDEPTH || pop))
        else $error("window queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("window queue read while empty");
    a_count_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!push.valid && !pop) |=> $stable(count_reg))
        else $error("window queue level changed without a push or pop");

endmodule

### design/c3f_back.sv
// ----------------------------------------------------------------------------
// c3f_back: kernel evaluation and result output
// Takes queued windows, issues one or two results each, evaluates the
// selected kernel per channel in two stages and holds the output word.
// ----------------------------------------------------------------------------
module c3f_back import c3f_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [1:0]     filter_mode,
    input  entry_t         head,
    input  logic [QCW-1:0] count,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [39:0]    m_tdata,
    output logic [1:0]     m_tuser,
    output logic           m_tlast
);

    logic        phase_reg;
    logic        out_adv, b1_load, issue, cur_b, cur_last;
    column_t     ca, cb, cc;

    logic                   b1_valid_reg, b1_eor_reg, b1_eof_reg, b1_last_reg;
    logic signed [11:0]     gx_reg  [3];
    logic signed [11:0]     gy_reg  [3];
    logic signed [12:0]     lap_reg [3];
    logic        [11:0]     box_reg [3];
    logic signed [11:0]     gx_next  [3];
    logic signed [11:0]     gy_next  [3];
    logic signed [12:0]     lap_next [3];
    logic        [11:0]     box_next [3];
    logic        [10:0]     chan_out [3];

    logic        m_tvalid_reg, m_tlast_reg;
    logic [39:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    // Stage handshakes: the output word frees when taken.
    assign out_adv  = !m_tvalid_reg || m_tready;
    assign b1_load  = !b1_valid_reg || out_adv;
    assign issue    = (count != '0) && b1_load;
    assign cur_b    = !head.emit_a || phase_reg;
    assign cur_last = cur_b || !head.emit_b;
    assign pop      = issue && cur_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else if (issue) begin
            phase_reg <= !cur_last;
        end
    end

    // Column choice: the row-end result replicates the right column.
    always_comb begin
        if (cur_b) begin
            ca = head.win[1];
            cb = head.win[2];
            cc = head.win[2];
        end else begin
            ca = head.win[0];
            cb = head.win[1];
            cc = head.win[2];
        end
    end

    // Raw kernel responses per channel.
    always_comb begin
        logic [9:0] v00, v01, v02, v10, v11, v12, v20, v21, v22;
        for (int ch = 0; ch < 3; ch++) begin
            v00 = 10'(ca[0][8*ch +: 8]);
            v01 = 10'(cb[0][8*ch +: 8]);
            v02 = 10'(cc[0][8*ch +: 8]);
            v10 = 10'(ca[1][8*ch +: 8]);
            v11 = 10'(cb[1][8*ch +: 8]);
            v12 = 10'(cc[1][8*ch +: 8]);
            v20 = 10'(ca[2][8*ch +: 8]);
            v21 = 10'(cb[2][8*ch +: 8]);
            v22 = 10'(cc[2][8*ch +: 8]);
            gx_next[ch]  = $signed({2'b00, v02 + (v12 << 1) + v22})
                         - $signed({2'b00, v00 + (v10 << 1) + v20});
            gy_next[ch]  = $signed({2'b00, v20 + (v21 << 1) + v22})
                         - $signed({2'b00, v00 + (v01 << 1) + v02});
            box_next[ch] = 12'(v00) + 12'(v01) + 12'(v02) + 12'(v10) + 12'(v11)
                         + 12'(v12) + 12'(v20) + 12'(v21) + 12'(v22);
            lap_next[ch] = $signed({1'b0, 12'(v11) * 12'd9}) - $signed({1'b0, box_next[ch]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
        end else if (b1_load) begin
            b1_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            gx_reg      <= gx_next;
            gy_reg      <= gy_next;
            lap_reg     <= lap_next;
            box_reg     <= box_next;
            b1_eor_reg  <= cur_b;
            b1_eof_reg  <= cur_b && head.eof;
            b1_last_reg <= cur_last;
        end
    end

    // Absolute value, clamp and divide by nine per channel.
    always_comb begin
        logic [11:0] ax, ay, cx, cy, al;
        logic [11:0] bs;
        logic [28:0] prod;
        for (int ch = 0; ch < 3; ch++) begin
            ax   = gx_reg[ch][11] ? 12'(-gx_reg[ch]) : 12'(gx_reg[ch]);
            ay   = gy_reg[ch][11] ? 12'(-gy_reg[ch]) : 12'(gy_reg[ch]);
            cx   = (32'(ax) > SOBEL_MAX) ? 12'(SOBEL_MAX) : ax;
            cy   = (32'(ay) > SOBEL_MAX) ? 12'(SOBEL_MAX) : ay;
            al   = lap_reg[ch][12] ? 12'(-lap_reg[ch]) : 12'(lap_reg[ch]);
            bs   = (32'(box_reg[ch]) > SMOOTH_MAX) ? 12'(SMOOTH_MAX) : box_reg[ch];
            prod = 29'(bs) * 29'(RECIP9);
            case (filter_mode)
                MODE_SOBEL:   chan_out[ch] = 11'(cx) + 11'(cy);
                MODE_LAPLACE: chan_out[ch] = (32'(al) > LAPLACE_MAX) ?
                                             11'(LAPLACE_MAX) : 11'(al);
                default:      chan_out[ch] = 11'(prod[28:16]);
            endcase
        end
    end

    // Output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_adv) begin
            m_tvalid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && b1_valid_reg) begin
            m_tdata_reg <= {5'd0, (filter_mode == MODE_SOBEL) ? 2'd2 : 2'd1,
                            chan_out[2], chan_out[1], chan_out[0]};
            m_tuser_reg <= {b1_eof_reg, b1_eor_reg};
            m_tlast_reg <= b1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### design/conv3x3_image_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_image_filter: 3x3 Sobel, Laplace and box filter on an RGB stream
// Raster-order pixels in, one filtered pixel per window out, edges replicated.
// ----------------------------------------------------------------------------
//  channel   direction  words
//  s_        in         pixel or drain word, one per clock while s_tready is high
//  m_        out        filtered pixel, one per clock while m_tready is high
//  cfg_      in         register write, no read-back
//
// A pixel word is taken every clock while the four-entry window queue has room.
// A row-end pixel can give two results; the output side takes one per clock
// while m_tready is high, so the queue soaks up the extra one. A word's first
// result passes the line store read at the taking edge, then the window
// update with queue write, the kernel sums and the output register.
// Reset clears positions and the window; line stores need no clearing.
// A stalled output holds its word; the input stalls once the queue fills.
module conv3x3_image_filter import c3f_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_red, pixel_green, pixel_blue
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_red, out_green, out_blue, pass_count, zero pad
    output logic [1:0]  m_tuser,   // end_of_row, end_of_frame
    output logic        m_tlast
);

    logic [1:0]     mode_reg;
    logic [11:0]    width_reg, height_reg;
    push_t          push;
    entry_t         head;
    logic [QCW-1:0] count;
    logic           pop;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_SOBEL;
            width_reg  <= 12'd2048;
            height_reg <= 12'd2048;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[1:0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    c3f_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .q_count      (count),
        .push         (push)
    );

    c3f_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .count   (count)
    );

    c3f_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .filter_mode (mode_reg),
        .head        (head),
        .count       (count),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

### dv/tb_conv3x3_image_filter.sv
// ----------------------------------------------------------------------------
// tb_conv3x3_image_filter: self-checking testbench of the 3x3 image filter
// Streams small frames in all three filter modes through the block, predicts
// each filtered pixel from its own window model and compares every result
// word field by field, under several idling and stalling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_conv3x3_image_filter;
    import c3f_pkg::*;

    localparam int LINE_DEPTH = 2048;

    typedef struct packed {
        logic [10:0] red;
        logic [10:0] green;
        logic [10:0] blue;
        logic [1:0]  passes;
        logic        row_end;
        logic        frame_end;
        logic        run_last;
    } pixel_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    conv3x3_image_filter dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // Predictor state.
    logic [1:0]  mode_q;
    logic [11:0] width_q;
    logic [11:0] height_q;
    logic [23:0] upper_store [LINE_DEPTH];
    logic [23:0] middle_store [LINE_DEPTH];
    logic [2:0][23:0] win_cols [3];
    int unsigned col_pos;
    int unsigned row_pos;

    pixel_result_t expected_pixels[$];
    int  errors;
    int  results_seen;
    int  words_sent;
    int  send_idle_pct;
    int  recv_stall_pct;

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous limit on the whole run.
    initial begin
        #20ms;
        $display("conv3x3_image_filter test failed");
        $finish;
    end

    // Filter one channel of a neighbourhood, v[row][col], upper row first.
    function automatic logic [10:0] filter_sample(input int v[3][3]);
        int gx;
        int gy;
        int s;
        if (mode_q == MODE_SOBEL) begin
            gx = (v[0][2] + 2 * v[1][2] + v[2][2]) - (v[0][0] + 2 * v[1][0] + v[2][0]);
            gy = (v[2][0] + 2 * v[2][1] + v[2][2]) - (v[0][0] + 2 * v[0][1] + v[0][2]);
            if (gx < 0) gx = -gx;
            if (gy < 0) gy = -gy;
            if (gx > 4 * 255) gx = 4 * 255;
            if (gy > 4 * 255) gy = 4 * 255;
            s = gx + gy;
        end else if (mode_q == MODE_LAPLACE) begin
            s = 9 * v[1][1];
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    s -= v[r][c];
            if (s < 0) s = -s;
            if (s > 255) s = 255;
        end else begin
            s = 0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    s += v[r][c];
            if (s > 9 * 255) s = 9 * 255;
            s = s / 9;
        end
        return s[10:0];
    endfunction

    // Filtered pixel from three window columns.
    function automatic pixel_result_t filtered_pixel(input int cl, input int cc, input int cr,
                                                     input logic eor, input logic eof);
        pixel_result_t res;
        int v[3][3];
        logic [10:0] ch_val[3];
        int idx[3];
        idx[0] = cl; idx[1] = cc; idx[2] = cr;
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    v[r][c] = int'(win_cols[idx[c]][r][8*ch +: 8]);
            ch_val[ch] = filter_sample(v);
        end
        res.red = ch_val[0];
        res.green = ch_val[1];
        res.blue = ch_val[2];
        res.passes = (mode_q == MODE_SOBEL) ? 2'd2 : 2'd1;
        res.row_end = eor;
        res.frame_end = eof;
        res.run_last = 1'b0;
        return res;
    endfunction

    // Advance the window model by one accepted word and queue its results.
    task automatic predict_word(input logic is_drain, input logic [23:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        logic [2:0][23:0] col;
        logic row_end;
        pixel_result_t res[$];
        w = (width_q == 0) ? 1 : width_q;
        h = (height_q == 0) ? 1 : height_q;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (h > 2048) h = 2048;
        if (is_drain != (row_pos >= h)) return;
        idx = (col_pos < LINE_DEPTH) ? col_pos : LINE_DEPTH - 1;
        if (is_drain) begin
            col[0] = upper_store[idx];
            col[1] = middle_store[idx];
            col[2] = middle_store[idx];
        end else begin
            if (row_pos == 0) begin
                col[0] = px;
                col[1] = px;
                upper_store[idx] = px;
            end else begin
                col[0] = upper_store[idx];
                col[1] = middle_store[idx];
                upper_store[idx] = col[1];
            end
            col[2] = px;
            middle_store[idx] = px;
        end
        if (col_pos == 0) begin
            win_cols[0] = col; win_cols[1] = col; win_cols[2] = col;
        end else begin
            win_cols[0] = win_cols[1]; win_cols[1] = win_cols[2]; win_cols[2] = col;
        end
        row_end = (col_pos + 1 >= w);
        if (row_pos >= 1) begin
            if (col_pos >= 1) res.push_back(filtered_pixel(0, 1, 2, 1'b0, 1'b0));
            if (row_end) res.push_back(filtered_pixel(1, 2, 2, 1'b1, is_drain));
            if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
            foreach (res[i]) expected_pixels.push_back(res[i]);
        end
        if (row_end) begin
            col_pos = 0;
            row_pos = is_drain ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    // Send one word, with random idle cycles ahead of it.
    task automatic send_word(input logic is_drain, input logic [23:0] px);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = is_drain;
        s_tdata  = px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_word(is_drain, px);
        words_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Wait for every expected result, then let the pipeline settle.
    task automatic wait_idle();
        int guard;
        guard = 0;
        while (expected_pixels.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [11:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (index == REG_MODE) mode_q = value[1:0];
        else if (index == REG_WIDTH) width_q = value;
        else if (index == REG_HEIGHT) height_q = value;
    endtask

    function automatic logic [23:0] random_pixel(input int flavour);
        case (flavour)
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return {3{($urandom_range(1) != 0) ? 8'hFF : 8'h00}};
            default: return 24'($urandom_range(24'hFFFFFF));
        endcase
    endfunction

    // One whole frame with its drain row; optional stray words are ignored.
    task automatic send_frame(input int w, input int h, input int flavour, input bit noise);
        int ew;
        int eh;
        // A zero width or height acts as one.
        ew = (w == 0) ? 1 : w;
        eh = (h == 0) ? 1 : h;
        write_reg(REG_WIDTH, w[11:0]);
        write_reg(REG_HEIGHT, h[11:0]);
        for (int i = 0; i < ew * eh; i++) begin
            if (noise && $urandom_range(15) == 0) send_word(1'b1, random_pixel(3));
            send_word(1'b0, random_pixel(flavour));
        end
        for (int i = 0; i < ew; i++) begin
            if (noise && $urandom_range(15) == 0) send_word(1'b0, random_pixel(3));
            send_word(1'b1, random_pixel(3));
        end
        wait_idle();
    endtask

    // Directed frames: extremes of the samples, every mode, tiny geometries.
    task automatic test_directed();
        write_reg(REG_MODE, 12'(MODE_SOBEL));
        send_frame(3, 3, 0, 0);
        send_frame(3, 3, 1, 0);
        write_reg(REG_MODE, 12'(MODE_LAPLACE));
        send_frame(1, 1, 1, 0);
        send_frame(2, 1, 2, 0);
        write_reg(REG_MODE, 12'(MODE_BOX));
        send_frame(1, 3, 1, 0);
        write_reg(REG_MODE, 12'd3);
        send_frame(2, 2, 3, 0);
    endtask

    // Random frames in random modes, with stray words in some of them.
    task automatic test_random_frames(input int word_goal);
        int start;
        start = words_sent;
        while (words_sent - start < word_goal) begin
            write_reg(REG_MODE, 12'($urandom_range(3)));
            send_frame($urandom_range(1, 9), $urandom_range(1, 5), $urandom_range(3),
                       $urandom_range(1) != 0);
        end
    endtask

    // A long single row, then a frame with zero width and height.
    task automatic test_geometry_extremes();
        write_reg(REG_MODE, 12'(MODE_SOBEL));
        send_frame(64, 1, 3, 0);
        send_frame(0, 0, 3, 0);
    endtask

    // Receiver stalls at random.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        pixel_result_t exp_px;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end else begin
                exp_px = expected_pixels.pop_front();
                if (m_tdata[10:0] !== exp_px.red) begin
                    $error("out_red expected %0d actual %0d", exp_px.red, m_tdata[10:0]);
                    errors++;
                end
                if (m_tdata[21:11] !== exp_px.green) begin
                    $error("out_green expected %0d actual %0d", exp_px.green, m_tdata[21:11]);
                    errors++;
                end
                if (m_tdata[32:22] !== exp_px.blue) begin
                    $error("out_blue expected %0d actual %0d", exp_px.blue, m_tdata[32:22]);
                    errors++;
                end
                if (m_tdata[34:33] !== exp_px.passes) begin
                    $error("pass_count expected %0d actual %0d", exp_px.passes,
                           m_tdata[34:33]);
                    errors++;
                end
                if (m_tuser[0] !== exp_px.row_end) begin
                    $error("end_of_row expected %0d actual %0d", exp_px.row_end, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== exp_px.frame_end) begin
                    $error("end_of_frame expected %0d actual %0d", exp_px.frame_end,
                           m_tuser[1]);
                    errors++;
                end
                if (m_tlast !== exp_px.run_last) begin
                    $error("last_of_run expected %0d actual %0d", exp_px.run_last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        errors = 0; results_seen = 0; words_sent = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_index = REG_MODE; cfg_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        mode_q = MODE_SOBEL; width_q = 12'd2048; height_q = 12'd2048;
        col_pos = 0; row_pos = 0;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            upper_store[i] = '0; middle_store[i] = '0;
        end
        for (int i = 0; i < 3; i++) win_cols[i] = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_frames(250);
        send_idle_pct = 59; recv_stall_pct = 0;
        test_random_frames(250);
        send_idle_pct = 0; recv_stall_pct = 59;
        test_random_frames(250);
        send_idle_pct = 27; recv_stall_pct = 27;
        test_random_frames(300);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_geometry_extremes();

        wait_idle();
        $display("Covered %0d input words and %0d filtered pixels in all modes,",
                 words_sent, results_seen);
        $display("frames from 1x1 to 64 wide, with idle and stall phases.");
        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("conv3x3_image_filter test passed");
        end else begin
            $display("conv3x3_image_filter test failed");
        end
        $finish;
    end

endmodule
